// ===== src/ffr_pkg.sv =====
package ffr_pkg;

  // frame buffer limit and derived widths
  localparam int FRAME_BYTES = 256;
  localparam int CNT_W       = $clog2(FRAME_BYTES + 2);
  localparam int CMP_W       = ((CNT_W > 9) ? CNT_W : 9) + 1;

  // request codes
  localparam logic [1:0] REQ_BYTE      = 2'd0;
  localparam logic [1:0] REQ_EOF       = 2'd1;
  localparam logic [1:0] REQ_TICK      = 2'd2;
  localparam logic [1:0] REQ_WRITE_ERR = 2'd3;

  // result status codes
  localparam logic [2:0] ST_WRITE    = 3'd0;
  localparam logic [2:0] ST_OOS      = 3'd1;
  localparam logic [2:0] ST_BAD_HEAD = 3'd2;
  localparam logic [2:0] ST_BAD_CHK  = 3'd3;
  localparam logic [2:0] ST_ACK      = 3'd4;
  localparam logic [2:0] ST_OTHER    = 3'd5;
  localparam logic [2:0] ST_RESEND   = 3'd6;

  // configuration register indexes
  localparam logic REG_FLASH_BASE   = 1'b0;
  localparam logic REG_NACK_SPACING = 1'b1;

  // frame constants
  localparam logic [7:0]  HEAD_LO        = 8'haa;
  localparam logic [7:0]  HEAD_HI        = 8'h55;
  localparam logic [7:0]  CMD_ACK        = 8'd1;
  localparam logic [7:0]  CMD_FIRMWARE   = 8'd6;
  localparam logic [7:0]  FW_OVERHEAD    = 8'd5;
  localparam logic [15:0] CRC_POLY_REFL  = 16'ha001;
  localparam logic [31:0] FLASH_BASE_RST = 32'h0800_4000;
  localparam logic [7:0]  NACK_SPACE_RST = 8'd5;

  typedef struct packed {
    logic [1:0] req_type;
    logic [7:0] rx_byte;
  } in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic        erase_first;
    logic [31:0] write_address;
    logic [7:0]  write_length;
    logic [15:0] expected_seq;
    logic [15:0] total_packets;
    logic        update_done;
    logic        send_ack;
    logic        nack_now;
  } out_t;

  // one entry of the reflected crc-16 table (entry 1 is 0xc0c1)
  function automatic logic [15:0] crc_entry(input logic [7:0] idx);
    logic [15:0] v;
    v = {8'd0, idx};
    for (int i = 0; i < 8; i++) begin
      v = v[0] ? ((v >> 1) ^ CRC_POLY_REFL) : (v >> 1);
    end
    return v;
  endfunction

endpackage

// ===== src/firmware_frame_receiver.sv =====
// firmware update frame receiver
// operation: a word accepted into the input stage is judged there and its result
//   registered in the result stage; a held result keeps it waiting in the input stage
// throughput: one input word per cycle; a held result stalls only the input stage
// reset: rst_n synchronous active low; clears frame state, sequence state, tick
//   counters and handshakes, and loads flash base 0x08004000 and nack spacing 5
module firmware_frame_receiver
  import ffr_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_t         in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_t        out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data
);

  // configuration registers
  logic [31:0] flash_base_r;
  logic [7:0]  nack_spacing_r;

  // input stage and result stage
  logic        in_valid_r;
  in_t         in_r;
  logic        out_valid_r;
  out_t        out_r;

  // frame under reception
  logic [CNT_W-1:0] byte_cnt_r,   byte_cnt_nxt;
  logic [15:0]      run_crc_r,    run_crc_nxt;
  logic             head_ok_r,    head_ok_nxt;
  logic [7:0]       frame_len_r,  frame_len_nxt;
  logic [7:0]       cmd_r,        cmd_nxt;
  logic [15:0]      frame_tot_r,  frame_tot_nxt;
  logic [15:0]      frame_seq_r,  frame_seq_nxt;
  logic [15:0]      rx_crc_r,     rx_crc_nxt;

  // session state
  logic [15:0] next_seq_r,     next_seq_nxt;
  logic [15:0] pkt_total_r,    pkt_total_nxt;
  logic [31:0] next_addr_r,    next_addr_nxt;
  logic        resend_r,       resend_nxt;
  logic [31:0] tick_cnt_r,     tick_cnt_nxt;
  logic [31:0] last_nack_r,    last_nack_nxt;

  logic advance;
  logic proc;
  logic res_valid;
  out_t res;

  // the result stage moves when empty or being taken; the input stage
  // refills whenever its word moves on
  assign advance   = !out_valid_r || out_ready;
  assign proc      = in_valid_r && advance;
  assign in_ready  = !in_valid_r || advance;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // byte position compared against length-relative offsets
  logic [CMP_W-1:0] pos_w;
  logic [CMP_W-1:0] crc_end_w;
  logic [CMP_W-1:0] need_w;
  logic [15:0]      seq_inc;
  logic [31:0]      wr_addr;
  logic [7:0]       wr_len;
  logic [31:0]      since_nack;

  assign pos_w      = CMP_W'(byte_cnt_r);
  assign crc_end_w  = CMP_W'(frame_len_r) + CMP_W'(7);
  assign need_w     = CMP_W'(frame_len_r) + CMP_W'(9);
  assign seq_inc    = next_seq_r + 16'd1;
  assign wr_len     = frame_len_r - FW_OVERHEAD;
  assign wr_addr    = (frame_seq_r == 16'd0) ? flash_base_r : next_addr_r;
  assign since_nack = tick_cnt_r - last_nack_r;

  always_comb begin
    byte_cnt_nxt  = byte_cnt_r;
    run_crc_nxt   = run_crc_r;
    head_ok_nxt   = head_ok_r;
    frame_len_nxt = frame_len_r;
    cmd_nxt       = cmd_r;
    frame_tot_nxt = frame_tot_r;
    frame_seq_nxt = frame_seq_r;
    rx_crc_nxt    = rx_crc_r;
    next_seq_nxt  = next_seq_r;
    pkt_total_nxt = pkt_total_r;
    next_addr_nxt = next_addr_r;
    resend_nxt    = resend_r;
    tick_cnt_nxt  = tick_cnt_r;
    last_nack_nxt = last_nack_r;
    res_valid     = 1'b0;
    res           = '0;

    case (in_r.req_type)
      REQ_BYTE: begin
        if (byte_cnt_r >= CNT_W'(FRAME_BYTES)) begin
          // overflow: saturate just past the buffer, byte not examined
          byte_cnt_nxt = CNT_W'(FRAME_BYTES + 1);
        end else begin
          if (byte_cnt_r == CNT_W'(0)) head_ok_nxt = (in_r.rx_byte == HEAD_LO);
          if (byte_cnt_r == CNT_W'(1)) head_ok_nxt = head_ok_r && (in_r.rx_byte == HEAD_HI);
          if (byte_cnt_r == CNT_W'(6)) frame_len_nxt = in_r.rx_byte;
          if (byte_cnt_r == CNT_W'(7)) cmd_nxt = in_r.rx_byte;
          if (byte_cnt_r == CNT_W'(8)) frame_tot_nxt[7:0] = in_r.rx_byte;
          if (byte_cnt_r == CNT_W'(9)) frame_tot_nxt[15:8] = in_r.rx_byte;
          if (byte_cnt_r == CNT_W'(10)) frame_seq_nxt[7:0] = in_r.rx_byte;
          if (byte_cnt_r == CNT_W'(11)) frame_seq_nxt[15:8] = in_r.rx_byte;
          if (byte_cnt_r >= CNT_W'(7)) begin
            // crc covers command byte onwards, then the crc itself low first
            if (pos_w < crc_end_w) begin
              run_crc_nxt = (run_crc_r >> 8) ^ crc_entry(run_crc_r[7:0] ^ in_r.rx_byte);
            end
            if (pos_w == crc_end_w) rx_crc_nxt[7:0] = in_r.rx_byte;
            if (pos_w == crc_end_w + CMP_W'(1)) rx_crc_nxt[15:8] = in_r.rx_byte;
          end
          byte_cnt_nxt = byte_cnt_r + CNT_W'(1);
        end
      end
      REQ_WRITE_ERR: begin
        // failed flash write restarts the transfer
        next_seq_nxt  = 16'd0;
        next_addr_nxt = flash_base_r;
      end
      REQ_TICK: begin
        tick_cnt_nxt = tick_cnt_r + 32'd1;
        if (resend_r) begin
          res_valid  = 1'b1;
          res.status = ST_RESEND;
        end
      end
      default: begin
        // end of frame: always one result, frame state cleared
        res_valid = 1'b1;
        if (byte_cnt_r < CNT_W'(2) || !head_ok_r) begin
          res.status = ST_BAD_HEAD;
        end else if (byte_cnt_r > CNT_W'(FRAME_BYTES) || frame_len_r == 8'd0 ||
                     pos_w < need_w || run_crc_r != rx_crc_r) begin
          res.status = ST_BAD_CHK;
        end else if (cmd_r == CMD_ACK) begin
          resend_nxt = 1'b0;
          res.status = ST_ACK;
        end else if (cmd_r != CMD_FIRMWARE) begin
          res.status = ST_OTHER;
        end else if (frame_len_r < FW_OVERHEAD) begin
          res.status = ST_BAD_CHK;
        end else begin
          resend_nxt   = 1'b1;
          res.send_ack = 1'b1;
          if (frame_seq_r == next_seq_r) begin
            pkt_total_nxt     = frame_tot_r;
            res.erase_first   = (frame_seq_r == 16'd0);
            res.write_address = wr_addr;
            res.write_length  = wr_len;
            next_addr_nxt     = wr_addr + {24'd0, wr_len};
            next_seq_nxt      = seq_inc;
            res.update_done   = (seq_inc >= frame_tot_r);
            res.status        = ST_WRITE;
          end else begin
            // out of sequence: resend request limited by tick spacing
            if (since_nack > {24'd0, nack_spacing_r}) begin
              last_nack_nxt = tick_cnt_r;
              res.nack_now  = 1'b1;
            end
            res.status = ST_OOS;
          end
        end
        byte_cnt_nxt  = '0;
        run_crc_nxt   = '0;
        head_ok_nxt   = 1'b0;
        frame_len_nxt = '0;
        cmd_nxt       = '0;
        frame_tot_nxt = '0;
        frame_seq_nxt = '0;
        rx_crc_nxt    = '0;
      end
    endcase
    res.expected_seq  = next_seq_nxt;
    res.total_packets = pkt_total_nxt;
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flash_base_r   <= FLASH_BASE_RST;
      nack_spacing_r <= NACK_SPACE_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_FLASH_BASE:   flash_base_r   <= cfg_data;
        REG_NACK_SPACING: nack_spacing_r <= cfg_data[7:0];
        default:          ;
      endcase
    end
  end

  // input stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_r <= in_data;
    end
  end

  // result stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= proc && res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (proc && res_valid) begin
      out_r <= res;
    end
  end

  // frame and session state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_cnt_r  <= '0;
      run_crc_r   <= '0;
      head_ok_r   <= 1'b0;
      frame_len_r <= '0;
      cmd_r       <= '0;
      frame_tot_r <= '0;
      frame_seq_r <= '0;
      rx_crc_r    <= '0;
      next_seq_r  <= '0;
      pkt_total_r <= '0;
      next_addr_r <= '0;
      resend_r    <= 1'b0;
      tick_cnt_r  <= '0;
      last_nack_r <= '0;
    end else if (proc) begin
      byte_cnt_r  <= byte_cnt_nxt;
      run_crc_r   <= run_crc_nxt;
      head_ok_r   <= head_ok_nxt;
      frame_len_r <= frame_len_nxt;
      cmd_r       <= cmd_nxt;
      frame_tot_r <= frame_tot_nxt;
      frame_seq_r <= frame_seq_nxt;
      rx_crc_r    <= rx_crc_nxt;
      next_seq_r  <= next_seq_nxt;
      pkt_total_r <= pkt_total_nxt;
      next_addr_r <= next_addr_nxt;
      resend_r    <= resend_nxt;
      tick_cnt_r  <= tick_cnt_nxt;
      last_nack_r <= last_nack_nxt;
    end
  end

  // byte counter saturates one past the buffer
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    byte_cnt_r <= CNT_W'(FRAME_BYTES + 1))
    else $error("byte counter beyond saturation");

  // end of frame always leaves an empty frame behind
  a_eof_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (proc && in_r.req_type == REQ_EOF) |=> (byte_cnt_r == '0 && !head_ok_r))
    else $error("frame state not cleared after end of frame");

  // a word with no result leaves the result stage empty
  a_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    (proc && !res_valid) |=> !out_valid_r)
    else $error("result shown for a word that has none");

  // rate-limited resend only on an out-of-sequence frame
  a_nack_oos: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.nack_now) |-> (out_r.status == ST_OOS && out_r.send_ack))
    else $error("resend request outside an out-of-sequence result");

  // a write result leaves the resend request pending
  a_write_pending: assert property (@(posedge clk) disable iff (!rst_n)
    (proc && res_valid && res.status == ST_WRITE) |=> resend_r)
    else $error("firmware frame did not leave resend pending");

endmodule
